>>> rtl/temporal_median_per_pixel_defines.svh
// assertion macros for the temporal median block
`ifndef TEMPORAL_MEDIAN_PER_PIXEL_DEFINES_SVH
`define TEMPORAL_MEDIAN_PER_PIXEL_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TMED_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define TMED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/tmed_pkg.sv
`timescale 1ns / 1ps
package tmed_pkg;

   localparam int CODE_W  = 8;
   localparam int FRAME_W = 17;

   localparam logic [FRAME_W-1:0] FRAME_RESET = 17'd65536;

   typedef logic [CODE_W-1:0]  code_type;
   typedef logic [FRAME_W-1:0] frame_type;

endpackage

>>> rtl/tmed_ram.sv
`timescale 1ns / 1ps
module tmed_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/temporal_median_per_pixel.sv
`timescale 1ns / 1ps
// Temporal median per pixel over the last WINDOW frames.
// Requests on req_* carry one depth code per pixel in raster order; results on
// rsp_* carry the pixel's median and a frame_end flag on the frame's last pixel.
// csr_* writes frame_pixels (0 acts as 1, above MAX_PIXELS acts as MAX_PIXELS);
// the user writes it only while no request is in flight; the block does not
// enforce this, and csr_ready is always high. Pipeline: pixel store read,
// oldest-entry removal, sorted insertion and write back, output register.
// Throughput is one pixel per cycle while rsp_ready stays high. A request whose
// pixel is still being updated in the pipeline waits, so frames of one or two
// pixels run below that rate; this is set by the store's read-modify-write.
// Reset sets the position to zero, the frame size to 65536 and the block to
// unprimed; the pixel store is not cleared, the first frame fills every slot
// of each pixel with its own value. When rsp_ready is low with a result
// waiting, the whole pipeline holds and req_ready drops; nothing is lost.
module temporal_median_per_pixel #(
   parameter int WINDOW     = 3,
   parameter int MAX_PIXELS = 65536
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tmed_pkg::code_type  req_depth_code,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tmed_pkg::code_type  rsp_median_code,
   output logic                rsp_frame_end,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  tmed_pkg::frame_type csr_frame_pixels
);

   import tmed_pkg::*;

`include "temporal_median_per_pixel_defines.svh"

   localparam int AW   = $clog2(WINDOW);
   localparam int POSW = $clog2(MAX_PIXELS);
   localparam int CW   = (FRAME_W > POSW + 1) ? FRAME_W : POSW + 1;
   localparam int RW   = WINDOW * (CODE_W + AW);
   localparam int VOFF = WINDOW * AW;

   localparam logic [CW-1:0] MAX_N = CW'(MAX_PIXELS);
   localparam logic [AW-1:0] NEWEST = AW'(WINDOW - 1);

   // configuration and frame position
   frame_type         frame_ff;
   logic [POSW-1:0]   pos_ff, pos_in;
   logic              primed_ff, primed_in;
   logic [CW-1:0]     frame_n;
   logic [CW-1:0]     pos_plus;
   logic              last;
   logic              adv;
   logic              accept;

   // stage 1: store read data
   logic              s1_v_ff;
   logic [POSW-1:0]   s1_pos_ff;
   code_type          s1_x_ff;
   logic              s1_primed_ff;
   logic              s1_last_ff;
   logic [RW-1:0]     rdata;

   // stage 2: oldest removed, ages counted down
   logic              s2_v_ff;
   logic [POSW-1:0]   s2_pos_ff;
   code_type          s2_x_ff;
   logic              s2_last_ff;
   code_type          s2_val_ff [WINDOW-1];
   logic [AW-1:0]     s2_age_ff [WINDOW-1];
   code_type          s2_val_in [WINDOW-1];
   logic [AW-1:0]     s2_age_in [WINDOW-1];

   // output register
   logic              rsp_valid_ff;
   code_type          median_ff;
   logic              frame_end_ff;

   code_type          src_val [WINDOW];
   logic [AW-1:0]     src_age [WINDOW];
   logic              seen;
   logic [WINDOW-2:0] lt;
   code_type          ins_val [WINDOW];
   logic [AW-1:0]     ins_age [WINDOW];
   logic [RW-1:0]     wdata;
   logic              we;
   logic              hazard;

   assign adv      = !rsp_valid_ff || rsp_ready;
   assign hazard   = (s1_v_ff && (s1_pos_ff == pos_ff)) || (s2_v_ff && (s2_pos_ff == pos_ff));
   assign req_ready = adv && !hazard;
   assign accept   = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      if (frame_ff == '0) begin
         frame_n = CW'(1);
      end else if (CW'(frame_ff) > MAX_N) begin
         frame_n = MAX_N;
      end else begin
         frame_n = CW'(frame_ff);
      end
      pos_plus  = CW'(pos_ff) + CW'(1);
      last      = (pos_plus >= frame_n);
      pos_in    = pos_ff;
      primed_in = primed_ff;
      if (accept) begin
         if (last) begin
            pos_in    = '0;
            primed_in = 1'b1;
         end else begin
            pos_in = pos_plus[POSW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff  <= FRAME_RESET;
         pos_ff    <= '0;
         primed_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            frame_ff <= csr_frame_pixels;
         end
         pos_ff    <= pos_in;
         primed_ff <= primed_in;
      end
   end

   tmed_ram #(
      .WIDTH(RW),
      .DEPTH(MAX_PIXELS)
   ) u_store (
      .clock(clock),
      .we   (we),
      .waddr(s2_pos_ff),
      .wdata(wdata),
      .re   (adv),
      .raddr(pos_ff),
      .rdata(rdata)
   );

   // stage 1 logic: fill on the first frame, drop the oldest entry
   always_comb begin
      for (int k = 0; k < WINDOW; k++) begin
         if (s1_primed_ff) begin
            src_val[k] = rdata[VOFF + k*CODE_W +: CODE_W];
            src_age[k] = rdata[k*AW +: AW];
         end else begin
            src_val[k] = s1_x_ff;
            src_age[k] = AW'(k);
         end
      end
      seen = 1'b0;
      for (int k = 0; k < WINDOW - 1; k++) begin
         seen = seen || (src_age[k] == '0);
         if (seen) begin
            s2_val_in[k] = src_val[k+1];
            s2_age_in[k] = src_age[k+1];
         end else begin
            s2_val_in[k] = src_val[k];
            s2_age_in[k] = src_age[k];
         end
         if (s2_age_in[k] != '0) begin
            s2_age_in[k] = s2_age_in[k] - AW'(1);
         end
      end
   end

   // stage 2 logic: sorted insertion of the new value
   always_comb begin
      for (int k = 0; k < WINDOW - 1; k++) begin
         lt[k] = s2_val_ff[k] < s2_x_ff;
      end
      if (lt[0]) begin
         ins_val[0] = s2_val_ff[0];
         ins_age[0] = s2_age_ff[0];
      end else begin
         ins_val[0] = s2_x_ff;
         ins_age[0] = NEWEST;
      end
      for (int k = 1; k < WINDOW - 1; k++) begin
         if (lt[k]) begin
            ins_val[k] = s2_val_ff[k];
            ins_age[k] = s2_age_ff[k];
         end else if (lt[k-1]) begin
            ins_val[k] = s2_x_ff;
            ins_age[k] = NEWEST;
         end else begin
            ins_val[k] = s2_val_ff[k-1];
            ins_age[k] = s2_age_ff[k-1];
         end
      end
      if (lt[WINDOW-2]) begin
         ins_val[WINDOW-1] = s2_x_ff;
         ins_age[WINDOW-1] = NEWEST;
      end else begin
         ins_val[WINDOW-1] = s2_val_ff[WINDOW-2];
         ins_age[WINDOW-1] = s2_age_ff[WINDOW-2];
      end
      for (int k = 0; k < WINDOW; k++) begin
         wdata[VOFF + k*CODE_W +: CODE_W] = ins_val[k];
         wdata[k*AW +: AW]                = ins_age[k];
      end
   end

   assign we = adv && s2_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff      <= accept;
         s2_v_ff      <= s1_v_ff;
         rsp_valid_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pos_ff    <= pos_ff;
         s1_x_ff      <= req_depth_code;
         s1_primed_ff <= primed_ff;
         s1_last_ff   <= last;
         s2_pos_ff    <= s1_pos_ff;
         s2_x_ff      <= s1_x_ff;
         s2_last_ff   <= s1_last_ff;
         s2_val_ff    <= s2_val_in;
         s2_age_ff    <= s2_age_in;
         median_ff    <= ins_val[WINDOW/2];
         frame_end_ff <= s2_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_median_code = median_ff;
   assign rsp_frame_end   = frame_end_ff;

   `TMED_ASSERT_SAME(a_no_pixel_overlap, clock, reset, s1_v_ff && s2_v_ff,
      s1_pos_ff != s2_pos_ff, "two requests for one pixel in flight")
   `TMED_ASSERT_NEXT(a_wrap_after_last, clock, reset, accept && last,
      pos_ff == '0 && primed_ff, "position did not wrap at frame end")
   `TMED_ASSERT_NEXT(a_stall_holds_update, clock, reset, s2_v_ff && !adv,
      s2_v_ff && $stable(s2_pos_ff), "pending update lost during stall")

endmodule

>>> test/tb_temporal_median_per_pixel.sv
`timescale 1ns / 1ps
module tb_temporal_median_per_pixel;

   import tmed_pkg::*;

   localparam int WIN             = 3;
   localparam int MAXPIX          = 65536;
   localparam int RANDOM_REQUESTS = 1030;
   localparam int STALL_LIMIT     = 1000;
   localparam int PLAN_ROWS       = 29;

   typedef struct packed {
      code_type median;
      logic     frame_end;
   } result_type;

   typedef enum logic {ROW_DEPTH, ROW_FRAME} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      frame_type    value;
      logic         typed;
      code_type     median;
      logic         frame_end;
   } row_type;

   logic      clock;
   logic      reset            = 1'b1;
   logic      req_valid        = 1'b0;
   logic      req_ready;
   code_type  req_depth_code   = '0;
   logic      rsp_valid;
   logic      rsp_ready        = 1'b0;
   code_type  rsp_median_code;
   logic      rsp_frame_end;
   logic      csr_valid        = 1'b0;
   logic      csr_ready;
   frame_type csr_frame_pixels = '0;

   temporal_median_per_pixel #(
      .WINDOW     (WIN),
      .MAX_PIXELS (MAXPIX)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_depth_code   (req_depth_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_median_code  (rsp_median_code),
      .rsp_frame_end    (rsp_frame_end),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_frame_pixels (csr_frame_pixels)
   );

   // per-pixel window, kept sorted, with age tags
   code_type    win_val [MAXPIX][WIN];
   logic [1:0]  win_age [MAXPIX][WIN];
   int unsigned px_pos        = 0;
   bit          px_primed     = 1'b0;
   frame_type   frame_reg     = FRAME_RESET;
   int unsigned pixels_filled = 0;

   result_type median_due [$];
   bit      calm = 1'b0;
   int      requests_sent   = 0;
   int      results_checked = 0;
   int      frame_ends_seen = 0;
   int      frame_writes    = 0;
   int      mismatches      = 0;

   row_type plan [PLAN_ROWS] = '{
      '{ROW_DEPTH, 17'h000FF & 17'h00, 1'b1, 8'h00, 1'b0},
      '{ROW_DEPTH, 17'h000FF,          1'b1, 8'hFF, 1'b0},
      '{ROW_DEPTH, 17'h00001,          1'b1, 8'h01, 1'b0},
      '{ROW_DEPTH, 17'h00080,          1'b1, 8'h80, 1'b0},
      '{ROW_FRAME, 17'h1FFFF,          1'b0, 8'h00, 1'b0},
      '{ROW_DEPTH, 17'h0007F,          1'b1, 8'h7F, 1'b0},
      '{ROW_DEPTH, 17'h000FE,          1'b1, 8'hFE, 1'b0},
      '{ROW_FRAME, 17'h10000,          1'b0, 8'h00, 1'b0},
      '{ROW_DEPTH, 17'h00055,          1'b1, 8'h55, 1'b0},
      '{ROW_DEPTH, 17'h000AA,          1'b1, 8'hAA, 1'b0},
      '{ROW_DEPTH, 17'h00033,          1'b1, 8'h33, 1'b0},
      '{ROW_DEPTH, 17'h000CC,          1'b1, 8'hCC, 1'b0},
      '{ROW_FRAME, 17'h00000,          1'b0, 8'h00, 1'b0},
      '{ROW_DEPTH, 17'h0000F,          1'b1, 8'h0F, 1'b1},
      '{ROW_DEPTH, 17'h000FF,          1'b0, 8'h00, 1'b0},
      '{ROW_DEPTH, 17'h000FF,          1'b0, 8'h00, 1'b0},
      '{ROW_FRAME, 17'h00001,          1'b0, 8'h00, 1'b0},
      '{ROW_DEPTH, 17'h00000,          1'b0, 8'h00, 1'b0},
      '{ROW_FRAME, 17'h00002,          1'b0, 8'h00, 1'b0},
      '{ROW_DEPTH, 17'h00010,          1'b0, 8'h00, 1'b0},
      '{ROW_DEPTH, 17'h00020,          1'b0, 8'h00, 1'b0},
      '{ROW_DEPTH, 17'h00030,          1'b0, 8'h00, 1'b0},
      '{ROW_FRAME, 17'd11,             1'b0, 8'h00, 1'b0},
      '{ROW_DEPTH, 17'h00040,          1'b0, 8'h00, 1'b0},
      '{ROW_DEPTH, 17'h00040,          1'b0, 8'h00, 1'b0},
      '{ROW_DEPTH, 17'h00040,          1'b0, 8'h00, 1'b0},
      '{ROW_FRAME, 17'd3,              1'b0, 8'h00, 1'b0},
      '{ROW_DEPTH, 17'h000FF,          1'b0, 8'h00, 1'b0},
      '{ROW_DEPTH, 17'h00000,          1'b0, 8'h00, 1'b0}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic result_type advance_pixel_window(code_type x);
      int unsigned span;
      int unsigned p;
      int          k;
      int          oldest;
      int          slot;
      result_type  r;
      span = frame_reg;
      if (span == 0) span = 1;
      if (span > MAXPIX) span = MAXPIX;
      p = px_pos;
      if (p >= MAXPIX) p = 0;
      if (!px_primed) begin
         for (k = 0; k < WIN; k++) begin
            win_val[p][k] = x;
            win_age[p][k] = 2'(k);
         end
      end
      oldest = 0;
      for (k = 1; k < WIN; k++)
         if (win_age[p][k] < win_age[p][oldest]) oldest = k;
      for (k = oldest; k < WIN - 1; k++) begin
         win_val[p][k] = win_val[p][k+1];
         win_age[p][k] = win_age[p][k+1];
      end
      slot = 0;
      for (k = 0; k < WIN - 1; k++) begin
         if (win_age[p][k] > 0) win_age[p][k] = win_age[p][k] - 2'd1;
         if (win_val[p][k] < x) slot++;
      end
      for (k = WIN - 1; k > slot; k--) begin
         win_val[p][k] = win_val[p][k-1];
         win_age[p][k] = win_age[p][k-1];
      end
      win_val[p][slot] = x;
      win_age[p][slot] = 2'(WIN - 1);
      r.median    = win_val[p][WIN/2];
      r.frame_end = (p + 1 >= span);
      if (r.frame_end) begin
         if (!px_primed) pixels_filled = p + 1;
         px_pos    = 0;
         px_primed = 1'b1;
      end else begin
         px_pos = p + 1;
      end
      return r;
   endfunction

   function automatic void flag_error(string msg);
      mismatches++;
      if (mismatches <= 10) $display("error: %s", msg);
   endfunction

   task automatic send_depth(input code_type code, input bit typed, input result_type typed_res);
      result_type got;
      while (!calm && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_depth_code <= code;
      do @(posedge clock); while (req_ready !== 1'b1);
      got = advance_pixel_window(code);
      median_due.insert(median_due.size(), typed ? typed_res : got);
      requests_sent++;
   endtask

   task automatic write_frame_size(input frame_type size);
      req_valid <= 1'b0;
      while (median_due.size() != 0) @(posedge clock);
      csr_valid        <= 1'b1;
      csr_frame_pixels <= size;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      frame_reg = size;
      frame_writes++;
   endtask

   initial begin : stimulus
      int       i;
      int       n;
      int       burst;
      int       mode;
      int       pick;
      code_type code;
      code_type last_code;
      frame_type size;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < PLAN_ROWS; i++) begin
         if (plan[i].kind == ROW_FRAME)
            write_frame_size(plan[i].value);
         else
            send_depth(plan[i].value[7:0], plan[i].typed, {plan[i].median, plan[i].frame_end});
      end

      n         = 0;
      last_code = '0;
      while (n < RANDOM_REQUESTS) begin
         if ($urandom_range(99) < 40) begin
            // frames may never outgrow what the first frame filled
            pick = $urandom_range(99);
            if (pick < 8)       size = '0;
            else if (pick < 16) size = 17'd1;
            else if (pick < 26) size = 17'd2;
            else if (pick < 40) size = frame_type'(pixels_filled);
            else                size = frame_type'($urandom_range(pixels_filled, 3));
            write_frame_size(size);
         end
         burst = $urandom_range(60, 5);
         mode  = $urandom_range(3);
         for (i = 0; i < burst && n < RANDOM_REQUESTS; i++) begin
            calm = (n >= 400 && n < 650);
            case (mode)
               0: code = code_type'($urandom_range(255));
               1: code = code_type'($urandom_range(3));
               2: code = $urandom_range(1) ? 8'hFF : 8'h00;
               default: code = $urandom_range(1) ? last_code : code_type'($urandom_range(255));
            endcase
            last_code = code;
            send_depth(code, 1'b0, '0);
            n++;
         end
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (median_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (median_due.size() != 0)
         flag_error($sformatf("%0d results never arrived", median_due.size()));

      $display("run: %0d depth requests, %0d results checked, %0d frame ends",
               requests_sent, results_checked, frame_ends_seen);
      $display("run: %0d frame size writes incl. zero and above the pixel limit, %0d errors",
               frame_writes, mismatches);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   always @(posedge clock) begin : result_check
      result_type want;
      rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 11);
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (median_due.size() == 0) begin
            flag_error($sformatf("unexpected result median=%02h frame_end=%0b",
                                 rsp_median_code, rsp_frame_end));
         end else begin
            want = median_due.pop_front();
            results_checked++;
            if (rsp_frame_end === 1'b1) frame_ends_seen++;
            if (rsp_median_code !== want.median || rsp_frame_end !== want.frame_end)
               flag_error($sformatf("result %0d: expected %02h/%0b, got %02h/%0b",
                                    results_checked, want.median, want.frame_end,
                                    rsp_median_code, rsp_frame_end));
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_ready === 1'b1) ||
             (rsp_valid === 1'b1 && rsp_ready === 1'b1) ||
             (csr_valid === 1'b1 && csr_ready === 1'b1) || reset)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout: no request, result or register write for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
